FILE: hw/rtl/mcgd_pkg.sv
// Package for the mouse click gesture detector.
// Holds the report item type, button and gesture codes and the window reset value.
// No dependencies.
`default_nettype none

package mcgd_pkg;

    localparam int BTN_WIDTH  = 3;
    localparam int TIME_BITS  = 32;
    localparam int WIN_WIDTH  = 16;
    localparam int HIST_DEPTH = 3;

    localparam logic [BTN_WIDTH-1:0] BTN_NONE = 3'd0;
    localparam logic [BTN_WIDTH-1:0] BTN_LEFT = 3'd1;

    localparam logic [1:0] GESTURE_NONE   = 2'd0;
    localparam logic [1:0] GESTURE_DOUBLE = 2'd1;
    localparam logic [1:0] GESTURE_SLIDE  = 2'd2;
    localparam logic [1:0] GESTURE_TRIPLE = 2'd3;

    localparam logic [WIN_WIDTH-1:0] WINDOW_RESET = 16'd600;

    typedef struct packed {
        logic [BTN_WIDTH-1:0] buttons;
        logic [TIME_BITS-1:0] time_ms;
    } t_item;

endpackage

`default_nettype wire

FILE: hw/rtl/mcgd_in_reg.sv
// Input register stage of the mouse click gesture detector.
// Captures one report item and holds it until the core takes it; uses mcgd_pkg.
`default_nettype none

module mcgd_in_reg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire mcgd_pkg::t_item i_item,
    input  wire logic           i_take,
    output logic                o_stall,
    output logic                o_valid,
    output mcgd_pkg::t_item     o_item
);
    import mcgd_pkg::*;

    logic   r_valid;
    t_item  r_item;
    logic   accept;

    // stall only while the held item cannot move on
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: hw/rtl/mcgd_core.sv
// Gesture state and decision logic of the mouse click gesture detector.
// Keeps the button history, timing state and window register; uses mcgd_pkg.
`default_nettype none

module mcgd_core #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_update,
    input  wire mcgd_pkg::t_item               i_item,
    input  wire logic                          i_cfg_we,
    input  wire logic [mcgd_pkg::WIN_WIDTH-1:0] i_cfg_wdata,
    output logic [1:0]                         o_gesture
);
    import mcgd_pkg::*;

    logic [BTN_WIDTH-1:0]  r_hist [HIST_DEPTH];
    logic [BTN_WIDTH-1:0]  n_hist [HIST_DEPTH];
    logic                  r_rel, n_rel;
    logic                  r_tp, n_tp;
    logic [TIME_WIDTH-1:0] r_pt, n_pt;
    logic [TIME_WIDTH-1:0] r_ldt, n_ldt;
    logic [WIN_WIDTH-1:0]  r_win;

    logic [BTN_WIDTH-1:0]  b;
    logic [TIME_WIDTH-1:0] now;
    logic [TIME_WIDTH-1:0] win_ext;
    logic [TIME_WIDTH-1:0] el_ldt;
    logic [TIME_WIDTH-1:0] el_pt;
    logic                  rel_a, press, in_tri, dbl, slide, clr;
    logic [1:0]            gest;

    assign b       = i_item.buttons;
    assign now     = TIME_WIDTH'(i_item.time_ms);
    assign win_ext = TIME_WIDTH'(r_win);
    assign el_ldt  = now - r_ldt;
    assign el_pt   = now - r_pt;

    always_comb begin
        rel_a  = r_rel || (b == BTN_NONE && r_hist[0] == BTN_NONE);
        press  = (b == BTN_LEFT) && (r_hist[0] == BTN_NONE) && rel_a;
        in_tri = (r_ldt != '0) && (el_ldt < win_ext);
        dbl    = (b == BTN_NONE) && (r_hist[0] == BTN_LEFT) &&
                 (r_hist[1] == BTN_NONE) && (r_hist[2] == BTN_LEFT);
        slide  = (b == BTN_NONE) && (r_hist[0] == BTN_LEFT) &&
                 (r_hist[1] == BTN_LEFT) && (r_hist[2] == BTN_LEFT);

        n_rel = rel_a;
        n_tp  = r_tp;
        n_pt  = r_pt;
        n_ldt = r_ldt;
        clr   = 1'b0;
        gest  = GESTURE_NONE;

        if (press) begin
            n_rel = 1'b0;
            n_tp  = in_tri;
            if (!in_tri) begin
                n_pt = now;
            end
        end

        // a plain first press ends here; otherwise go on to the patterns
        if (!(press && !in_tri)) begin
            if (dbl) begin
                n_rel = 1'b1;
                if (el_pt > win_ext) begin
                    clr = 1'b1;
                end else begin
                    n_ldt = now;
                end
            end
            if (!(dbl && el_pt > win_ext) && (dbl || slide || n_tp)) begin
                clr = 1'b1;
                if (n_tp) begin
                    n_tp  = 1'b0;
                    n_rel = 1'b1;
                    gest  = GESTURE_TRIPLE;
                end else if (dbl) begin
                    gest = GESTURE_DOUBLE;
                end else begin
                    gest = GESTURE_SLIDE;
                end
            end
        end

        // shift the history, newest at the front, or drop it after a gesture
        if (clr) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                n_hist[k] = BTN_NONE;
            end
        end else begin
            n_hist[0] = b;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                n_hist[k] = r_hist[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist[k] <= BTN_NONE;
            end
            r_rel <= 1'b1;
            r_tp  <= 1'b0;
            r_pt  <= '0;
            r_ldt <= '0;
        end else if (i_update) begin
            r_hist <= n_hist;
            r_rel  <= n_rel;
            r_tp   <= n_tp;
            r_pt   <= n_pt;
            r_ldt  <= n_ldt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_win <= i_cfg_wdata;
        end
    end

    assign o_gesture = gest;

endmodule

`default_nettype wire

FILE: hw/rtl/mcgd_out_reg.sv
// Result register of the mouse click gesture detector.
// Holds one gesture item until the consumer takes it; uses mcgd_pkg.
`default_nettype none

module mcgd_out_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire logic [1:0] i_gesture,
    input  wire logic       i_stall,
    output logic            o_free,
    output logic            o_valid,
    output logic [1:0]      o_gesture
);
    import mcgd_pkg::*;

    logic       r_valid;
    logic [1:0] r_gesture;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gesture <= GESTURE_NONE;
        end else if (i_load) begin
            r_gesture <= i_gesture;
        end
    end

    assign o_valid   = r_valid;
    assign o_gesture = r_gesture;

endmodule

`default_nettype wire

FILE: hw/rtl/mouse_click_gesture_detector.sv
// Mouse click gesture detector: one gesture item for every report item.
// Path: an accepted item is held in the input register, then loaded into the result register,
// from which the consumer takes it; an output stall can hold it in either register.
// Throughput: one item per cycle while the output is not stalled; mcgd_core updates its state once per item.
// An output stall reaches o_in_stall in the same cycle once both registers hold an item.
// Reset: synchronous, active low; clears history, timing state and both stage valids,
// and sets the click window to 600 ms.
`default_nettype none

module mouse_click_gesture_detector #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_buttons,
    input  wire logic [31:0] i_time_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_gesture,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);
    import mcgd_pkg::*;

    t_item      in_item;
    t_item      s1_item;
    logic       s1_valid;
    logic       out_free;
    logic       advance;
    logic [1:0] core_gesture;

    assign in_item.buttons = i_buttons;
    assign in_item.time_ms = i_time_ms;
    assign advance         = s1_valid && out_free;

    mcgd_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .i_take  (out_free),
        .o_stall (o_in_stall),
        .o_valid (s1_valid),
        .o_item  (s1_item)
    );

    mcgd_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_update    (advance),
        .i_item      (s1_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_gesture   (core_gesture)
    );

    mcgd_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (advance),
        .i_gesture (core_gesture),
        .i_stall   (i_out_stall),
        .o_free    (out_free),
        .o_valid   (o_out_valid),
        .o_gesture (o_gesture)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/mcgd_checker.sv
// Port-level checks for the mouse click gesture detector.
// Bound to mouse_click_gesture_detector; no package needed.
`default_nettype none

module mcgd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [1:0] o_gesture
);

    // a stalled result item stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_gesture))
        else $error("stalled gesture changed");

    // input side stalls only with both stages full and the output blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the pipeline could advance");

    // an item accepted while no result is held shows on the result side unless the input side stalls after acceptance
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !o_out_valid) ##1 !o_in_stall |=> o_out_valid)
        else $error("result item missing after acceptance");

endmodule

bind mouse_click_gesture_detector mcgd_checker u_mcgd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_gesture   (o_gesture)
);

`default_nettype wire

FILE: bench/tb_mouse_click_gesture_detector.sv
// Testbench for mouse_click_gesture_detector: directed and random mouse reports, with
// gestures predicted by a scoreboard class and checked in order against the block.
// Depends on mcgd_pkg and the detector RTL only.
module tb_mouse_click_gesture_detector;

    import mcgd_pkg::*;

    // Predicts the gesture for each accepted report and holds the gestures still owed.
    class gesture_tracker;
        logic [BTN_WIDTH-1:0] history [4];
        logic [1:0]           slot;
        logic                 released;
        logic                 triple_pending;
        logic [TIME_BITS-1:0] press_time;
        logic [TIME_BITS-1:0] last_double_time;
        logic [WIN_WIDTH-1:0] window_ms;
        logic [1:0]           expected_gestures [$];
        int                   mismatches;
        int                   results_seen;
        int                   gesture_count [4];

        function new();
            foreach (history[k]) history[k] = BTN_NONE;
            slot             = 2'd0;
            released         = 1'b1;
            triple_pending   = 1'b0;
            press_time       = '0;
            last_double_time = '0;
            window_ms        = WINDOW_RESET;
            mismatches       = 0;
            results_seen     = 0;
            foreach (gesture_count[k]) gesture_count[k] = 0;
        endfunction

        function void clear_history();
            foreach (history[k]) history[k] = BTN_NONE;
        endfunction

        function logic [1:0] predict_gesture(logic [BTN_WIDTH-1:0] buttons,
                                             logic [TIME_BITS-1:0] now);
            logic [1:0] n1, n2, n3, n4;
            logic       is_double, is_slide;
            history[slot] = buttons;
            slot = slot + 2'd1;
            n1 = slot - 2'd1;
            n2 = slot - 2'd2;
            n3 = slot - 2'd3;
            n4 = slot;
            if (history[n1] == BTN_NONE && history[n2] == BTN_NONE)
                released = 1'b1;
            // a fresh left press either arms a triple or starts timing a pair
            if (history[n1] == BTN_LEFT && history[n2] == BTN_NONE && released) begin
                if (last_double_time != '0 && (now - last_double_time) < window_ms) begin
                    triple_pending = 1'b1;
                end else begin
                    press_time     = now;
                    triple_pending = 1'b0;
                end
                released = 1'b0;
                if (!triple_pending)
                    return GESTURE_NONE;
            end
            is_double = history[n1] == BTN_NONE && history[n2] == BTN_LEFT &&
                        history[n3] == BTN_NONE && history[n4] == BTN_LEFT;
            if (is_double) begin
                released = 1'b1;
                // too slow: drop the history and report nothing
                if ((now - press_time) > window_ms) begin
                    clear_history();
                    return GESTURE_NONE;
                end
                last_double_time = now;
            end
            is_slide = history[n1] == BTN_NONE && history[n2] == BTN_LEFT &&
                       history[n3] == BTN_LEFT && history[n4] == BTN_LEFT;
            if (!(is_double || is_slide || triple_pending))
                return GESTURE_NONE;
            clear_history();
            if (triple_pending) begin
                triple_pending = 1'b0;
                released       = 1'b1;
                return GESTURE_TRIPLE;
            end
            return is_double ? GESTURE_DOUBLE : GESTURE_SLIDE;
        endfunction

        function void note_report(logic [BTN_WIDTH-1:0] buttons, logic [TIME_BITS-1:0] now);
            expected_gestures.push_back(predict_gesture(buttons, now));
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_gesture(logic [1:0] got);
            logic [1:0] want;
            gesture_count[got]++;
            if (expected_gestures.size() == 0) begin
                report_mismatch($sformatf("gesture %0d arrived with none outstanding", got));
            end else begin
                want = expected_gestures.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("result %0d: gesture %0d, expected %0d",
                                              results_seen, got, want));
            end
            results_seen++;
        endtask
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [2:0]  i_buttons   = 3'd0;
    logic [31:0] i_time_ms   = 32'd0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = 16'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_gesture;

    gesture_tracker tracker = new();

    int          send_idle_pct = 14;
    int          recv_idle_pct = 86;
    int          reports_sent  = 0;
    int          window_writes = 0;
    logic [31:0] clock_ms      = 32'd0;

    mouse_click_gesture_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_buttons   (i_buttons),
        .i_time_ms   (i_time_ms),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_gesture   (o_gesture),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: check each accepted item, then choose the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_gesture(o_gesture);
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Valid stays high after an accepted item; lower it before any idle stretch.
    task automatic send_report(input logic [2:0] buttons, input logic [31:0] stamp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_buttons  <= buttons;
        i_time_ms  <= stamp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_report(buttons, stamp);
        reports_sent++;
    endtask

    // Advance the report clock, mostly within the window, now and then beyond it, or jump to a random stamp.
    task automatic send_timed(input logic [2:0] buttons, input int win);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            clock_ms = clock_ms + $urandom_range(0, win / 3 + 1);
        else if (r < 9)
            clock_ms = clock_ms + $urandom_range(0, 2 * win + 2);
        else
            clock_ms = $urandom();
        send_report(buttons, clock_ms);
    endtask

    task automatic send_random_burst(input int win);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            if ($urandom_range(0, 1))
                send_timed(BTN_NONE, win);
            send_timed(BTN_LEFT, win);
            send_timed(BTN_NONE, win);
            send_timed(BTN_LEFT, win);
            send_timed(BTN_NONE, win);
            if ($urandom_range(0, 1))
                send_timed(BTN_LEFT, win);
        end else if (kind < 6) begin
            repeat ($urandom_range(3, 4)) send_timed(BTN_LEFT, win);
            send_timed(BTN_NONE, win);
        end else if (kind < 7) begin
            repeat ($urandom_range(1, 2)) send_timed(BTN_NONE, win);
        end else begin
            repeat ($urandom_range(1, 4)) send_timed(3'($urandom_range(0, 7)), win);
        end
    endtask

    // Write only once every owed gesture has come back.
    task automatic write_window(input logic [15:0] value);
        i_in_valid <= 1'b0;
        while (tracker.expected_gestures.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        tracker.window_ms = value;
        window_writes++;
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [15:0] window_plan [6];
        int          stop_at;
        window_plan = '{16'd65535, 16'd0, 16'd1, 16'($urandom_range(2, 5000)),
                        WINDOW_RESET, 16'($urandom())};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // double, then triple on the next press
        send_report(BTN_LEFT, 32'd100);
        send_report(BTN_NONE, 32'd200);
        send_report(BTN_LEFT, 32'd300);
        send_report(BTN_NONE, 32'd400);
        send_report(BTN_LEFT, 32'd500);
        // slide
        send_report(BTN_LEFT, 32'd1700);
        send_report(BTN_LEFT, 32'd1800);
        send_report(BTN_LEFT, 32'd1900);
        send_report(BTN_NONE, 32'd2000);
        // pair too slow
        send_report(BTN_NONE, 32'd4900);
        send_report(BTN_LEFT, 32'd5000);
        send_report(BTN_NONE, 32'd5300);
        send_report(BTN_LEFT, 32'd5600);
        send_report(BTN_NONE, 32'd5700);
        // pair exactly on the window, third press exactly on the window
        send_report(BTN_LEFT, 32'd8000);
        send_report(BTN_NONE, 32'd8100);
        send_report(BTN_LEFT, 32'd8300);
        send_report(BTN_NONE, 32'd8600);
        send_report(BTN_LEFT, 32'd9200);
        // double across the counter wrap landing on zero: no triple may follow
        send_report(BTN_NONE, 32'hFFFF_FE00);
        send_report(BTN_NONE, 32'hFFFF_FE80);
        send_report(BTN_LEFT, 32'hFFFF_FF00);
        send_report(BTN_NONE, 32'hFFFF_FF80);
        send_report(BTN_LEFT, 32'hFFFF_FFFF);
        send_report(BTN_NONE, 32'h0000_0000);
        send_report(BTN_LEFT, 32'h0000_000A);
        send_report(3'd7, 32'h0000_0010);

        for (int p = 0; p < 6; p++) begin
            send_idle_pct = (p < 2) ? 14 : (p < 4) ? 86 : 0;
            recv_idle_pct = (p < 2) ? 86 : (p < 4) ? 14 : 0;
            write_window(window_plan[p]);
            stop_at = reports_sent + 160;
            while (reports_sent < stop_at)
                send_random_burst(int'(window_plan[p]));
        end

        i_in_valid <= 1'b0;
        while (tracker.expected_gestures.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d reports across %0d window settings and three idling profiles",
                 reports_sent, window_writes);
        $display("gestures seen: %0d double, %0d slide, %0d triple, %0d none",
                 tracker.gesture_count[GESTURE_DOUBLE], tracker.gesture_count[GESTURE_SLIDE],
                 tracker.gesture_count[GESTURE_TRIPLE], tracker.gesture_count[GESTURE_NONE]);
        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
